// ===== rtl/fmps_pkg.sv =====
`timescale 1ns / 1ps
package fmps_pkg;

    // frame store geometry
    localparam int FRAME_BUFFER_BYTES = 64;
    localparam int ADDR_W             = $clog2(FRAME_BUFFER_BYTES);
    localparam int WP_W               = 6;
    localparam int CNT_W              = 7;

    localparam logic [7:0] MSG_ID = 8'hA2;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_FIRST_PRE  = 2'd0;
    localparam logic [1:0] CFG_SECOND_PRE = 2'd1;
    localparam logic [1:0] CFG_COPY_LEN   = 2'd2;

    localparam logic [7:0]       FIRST_PRE_RST  = 8'd170;
    localparam logic [7:0]       SECOND_PRE_RST = 8'd85;
    localparam logic [CNT_W-1:0] COPY_LEN_RST   = 7'd64;

    // result event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_BYTE   = 2'd1;
    localparam logic [1:0] EV_BADSUM = 2'd2;
    localparam logic [1:0] EV_DROP   = 2'd3;

    typedef enum logic [2:0] {
        S_HUNT1,
        S_HUNT2,
        S_BODY,
        S_SUMLO,
        S_SUMHI,
        S_READ,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HUNT,
        OP_PRE2,
        OP_BODY,
        OP_SUMLO,
        OP_SUMHI
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       out_load;
        logic [1:0] out_ev;
        logic       out_from_store;
        logic       rd_start;
        logic       rd_issue;
        logic       rd_next;
    } dp_cmd_t;

    typedef struct packed {
        logic pre1_match;
        logic pre2_match;
        logic body_drop;
        logic body_done;
        logic sum_lo_match;
        logic sum_hi_match;
        logic copy_zero;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/framed_message_parser_sum16.sv =====
`timescale 1ns / 1ps
// each accepted byte loads its result into the output register in the next cycle
// throughput: one byte per cycle when hunting or in a frame and the output is free
// a good frame with copy length n > 0 (capped at 64) instead reads out n stored bytes
// (store read, then emit) plus any output stall; no byte is accepted during that run
// reset (async, active low): hunting first preamble, config to defaults, store reads zero
module framed_message_parser_sum16 (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // received byte beats
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    // result beats
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_res,
    output logic [7:0] frame_byte,
    output logic [5:0] byte_index,
    output logic       last_of_run
);
    import fmps_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: parse phases plus the readout sequence after a good frame
    fmps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: config registers, running sum, frame store and result register
    fmps_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_byte     (rx_byte),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .event_res   (event_res),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last_of_run (last_of_run)
    );

endmodule

// ===== rtl/fmps_dp.sv =====
`timescale 1ns / 1ps
module fmps_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic [7:0]        rx_byte,
    input  logic              out_ready,
    input  fmps_pkg::dp_cmd_t cmd,
    output fmps_pkg::dp_stat_t stat,
    output logic              out_valid,
    output logic [1:0]        event_res,
    output logic [7:0]        frame_byte,
    output logic [5:0]        byte_index,
    output logic              last_of_run
);
    import fmps_pkg::*;

    logic [7:0]       first_pre_reg;
    logic [7:0]       second_pre_reg;
    logic [CNT_W-1:0] copy_len_reg;

    logic [WP_W-1:0]  wp_reg, wp_next;
    logic [7:0]       dl_reg, dl_next;
    logic [15:0]      sum_reg, sum_next;

    logic [7:0]                    store_mem [FRAME_BUFFER_BYTES];
    logic [FRAME_BUFFER_BYTES-1:0] store_vld_reg;
    logic                          wr_en;
    logic [WP_W-1:0]               wr_pos;
    logic                          wr_hit;
    logic [ADDR_W-1:0]             wr_addr;

    logic [ADDR_W-1:0] rd_cnt_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_vld_reg;
    logic [CNT_W-1:0]  copy_n;

    logic              out_valid_reg;
    logic [1:0]        event_reg;
    logic [7:0]        fbyte_reg;
    logic [5:0]        idx_reg;
    logic              last_reg;

    logic [WP_W-1:0]   wp_inc;
    logic [7:0]        dl_eff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pre_reg  <= FIRST_PRE_RST;
            second_pre_reg <= SECOND_PRE_RST;
            copy_len_reg   <= COPY_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_PRE:  first_pre_reg  <= cfg_data;
                CFG_SECOND_PRE: second_pre_reg <= cfg_data;
                CFG_COPY_LEN:   copy_len_reg   <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign wp_inc = wp_reg + WP_W'(1);
    assign dl_eff = (wp_reg == WP_W'(2)) ? rx_byte : dl_reg;

    // parse state update and store write position
    always_comb
    begin
        wp_next  = wp_reg;
        dl_next  = dl_reg;
        sum_next = sum_reg;
        wr_en    = 1'b0;
        wr_pos   = wp_reg;
        case (cmd.op)
            OP_HUNT:
            begin
                wp_next  = '0;
                sum_next = {8'd0, rx_byte};
                wr_en    = 1'b1;
                wr_pos   = '0;
            end
            OP_PRE2:
            begin
                wp_next  = WP_W'(2);
                sum_next = sum_reg + {8'd0, rx_byte};
                wr_en    = 1'b1;
                wr_pos   = WP_W'(1);
            end
            OP_BODY:
            begin
                dl_next  = dl_eff;
                wp_next  = wp_inc;
                sum_next = sum_reg + {8'd0, rx_byte};
                wr_en    = 1'b1;
            end
            OP_SUMLO:
            begin
                wp_next = wp_inc;
                wr_en   = 1'b1;
            end
            OP_SUMHI:
            begin
                wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    assign wr_hit  = wr_en && ({1'b0, wr_pos} < (WP_W + 1)'(FRAME_BUFFER_BYTES));
    assign wr_addr = wr_pos[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            dl_reg  <= '0;
            sum_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            dl_reg  <= dl_next;
            sum_reg <= sum_next;
        end
    end

    // frame store: entries not yet written read as zero
    always_ff @(posedge clk)
    begin
        if (wr_hit)
            store_mem[wr_addr] <= rx_byte;
        if (cmd.rd_issue)
            rd_data_reg <= store_mem[rd_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_cnt_reg    <= '0;
        end
        else
        begin
            if (wr_hit)
                store_vld_reg[wr_addr] <= 1'b1;
            if (cmd.rd_issue)
                rd_vld_reg <= store_vld_reg[rd_cnt_reg];
            if (cmd.rd_start)
                rd_cnt_reg <= '0;
            else if (cmd.rd_next)
                rd_cnt_reg <= rd_cnt_reg + ADDR_W'(1);
        end
    end

    // readout length, saturated to the store size
    assign copy_n = (copy_len_reg > CNT_W'(FRAME_BUFFER_BYTES)) ?
                    CNT_W'(FRAME_BUFFER_BYTES) : copy_len_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_from_store)
            begin
                event_reg <= EV_BYTE;
                fbyte_reg <= rd_vld_reg ? rd_data_reg : 8'd0;
                idx_reg   <= 6'(rd_cnt_reg);
                last_reg  <= stat.rd_last;
            end
            else
            begin
                event_reg <= cmd.out_ev;
                fbyte_reg <= 8'd0;
                idx_reg   <= 6'd0;
                last_reg  <= 1'b1;
            end
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.pre1_match   = (rx_byte == first_pre_reg);
        stat.pre2_match   = (rx_byte == second_pre_reg);
        stat.body_drop    = ({1'b0, wp_reg} >= (WP_W + 1)'(FRAME_BUFFER_BYTES - 2)) ||
                            ((wp_reg == WP_W'(3)) && (rx_byte != MSG_ID));
        stat.body_done    = ({3'd0, wp_inc} + 9'd2) >= {1'b0, dl_eff};
        stat.sum_lo_match = (rx_byte == sum_reg[7:0]);
        stat.sum_hi_match = (rx_byte == sum_reg[15:8]);
        stat.copy_zero    = (copy_len_reg == '0);
        stat.rd_last      = ((CNT_W'(rd_cnt_reg) + CNT_W'(1)) == copy_n);
        stat.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign frame_byte  = fbyte_reg;
    assign byte_index  = idx_reg;
    assign last_of_run = last_reg;

endmodule

// ===== rtl/fmps_ctrl.sv =====
`timescale 1ns / 1ps
module fmps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fmps_pkg::dp_stat_t stat,
    output fmps_pkg::dp_cmd_t  cmd
);
    import fmps_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        parsing;
    logic        fire;

    assign parsing  = (state_reg == S_HUNT1) || (state_reg == S_HUNT2) ||
                      (state_reg == S_BODY) || (state_reg == S_SUMLO) ||
                      (state_reg == S_SUMHI);
    assign in_ready = parsing && stat.out_free;
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_HUNT1;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_HUNT1:
                if (fire)
                    state_next = stat.pre1_match ? S_HUNT2 : S_HUNT1;
            S_HUNT2:
                if (fire)
                    state_next = stat.pre2_match ? S_BODY : S_HUNT1;
            S_BODY:
                if (fire)
                begin
                    if (stat.body_drop)
                        state_next = S_HUNT1;
                    else if (stat.body_done)
                        state_next = S_SUMLO;
                end
            S_SUMLO:
                if (fire)
                    state_next = stat.sum_lo_match ? S_SUMHI : S_HUNT1;
            S_SUMHI:
                if (fire)
                    state_next = (stat.sum_hi_match && !stat.copy_zero) ? S_READ : S_HUNT1;
            S_READ:
                state_next = S_EMIT;
            S_EMIT:
                if (stat.out_free)
                    state_next = stat.rd_last ? S_HUNT1 : S_READ;
            default:
                state_next = S_HUNT1;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '{op: OP_NONE, out_ev: EV_NONE, default: 1'b0};
        case (state_reg)
            S_HUNT1:
                if (fire)
                begin
                    cmd.op       = OP_HUNT;
                    cmd.out_load = 1'b1;
                end
            S_HUNT2:
                if (fire)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.pre2_match)
                        cmd.op = OP_PRE2;
                    else
                        cmd.out_ev = EV_DROP;
                end
            S_BODY:
                if (fire)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.body_drop)
                        cmd.out_ev = EV_DROP;
                    else
                        cmd.op = OP_BODY;
                end
            S_SUMLO:
                if (fire)
                begin
                    cmd.op       = OP_SUMLO;
                    cmd.out_load = 1'b1;
                    if (!stat.sum_lo_match)
                        cmd.out_ev = EV_BADSUM;
                end
            S_SUMHI:
                if (fire)
                begin
                    cmd.op = OP_SUMHI;
                    if (!stat.sum_hi_match)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_ev   = EV_BADSUM;
                    end
                    else if (stat.copy_zero)
                        cmd.out_load = 1'b1;
                    else
                        cmd.rd_start = 1'b1;
                end
            S_READ:
                cmd.rd_issue = 1'b1;
            S_EMIT:
                if (stat.out_free)
                begin
                    cmd.out_load       = 1'b1;
                    cmd.out_from_store = 1'b1;
                    cmd.rd_next        = !stat.rd_last;
                end
            default: ;
        endcase
    end

    // a result is never loaded over one that has not been taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten");

    // a store read is always followed by its emit slot
    a_read_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_EMIT))
        else $error("read not followed by emit");

    // a bad low checksum byte ends the frame
    a_badsum_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (state_reg == S_SUMLO) && !stat.sum_lo_match) |=> (state_reg == S_HUNT1))
        else $error("bad low checksum did not restart hunt");

    // a good frame with a non-zero copy length starts a readout
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (state_reg == S_SUMHI) && stat.sum_hi_match && !stat.copy_zero)
        |=> (state_reg == S_READ))
        else $error("accepted frame did not start readout");

endmodule

// ===== tb/framed_message_parser_sum16_test.sv =====
`timescale 1ns / 1ps
module framed_message_parser_sum16_test;
    import fmps_pkg::*;

    // cycles with no beat either side or config write before the run is declared hung
    // (covers the long receiver hold-off plus a full 64-byte readout)
    localparam int STALL_LIMIT  = 3000;
    // the block's answers come from its output register, so a short settle is plenty
    localparam int SETTLE_LIMIT = 4;
    // length of the deliberate receiver hold-off
    localparam int HOLD_CYCLES  = 400;

    // ways of spoiling a generated frame
    localparam int FAULT_NONE  = 0;
    localparam int FAULT_PRE2  = 1;
    localparam int FAULT_ID    = 2;
    localparam int FAULT_SUMLO = 3;
    localparam int FAULT_SUMHI = 4;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        COLLECT,
        CHECK_LO,
        CHECK_HI
    } parse_phase_t;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
        logic [5:0] idx;
        logic       last;
    } frame_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_FIRST_PRE;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] event_res;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       last_of_run;

    // parser mirror: configuration
    logic [7:0] pre1_cfg;
    logic [7:0] pre2_cfg;
    logic [6:0] copy_cfg;

    // parser mirror: state
    parse_phase_t phase;
    logic [5:0]   wr_pos;
    logic [7:0]   len_byte;
    logic [15:0]  frame_sum;
    logic [7:0]   frame_store [64];

    // bytes waiting to be sent, and results still owed by the block
    logic [7:0]    rx_pending [$];
    frame_result_t expected_results [$];
    int            queued;

    // sender bookkeeping
    bit sending;
    bit in_beat_taken;
    int burst_left;
    int gap_left;

    // receiver bookkeeping
    bit hold_off_request;
    bit rdy;
    int hold_left;
    int rx_mode;
    int seg_left;

    int mismatches;
    int idle_cycles;
    int ph;

    framed_message_parser_sum16 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    // advance the parser mirror by one received byte and queue what it owes
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [1:0] ev;
        bit         accept;
        int         n;
        int         i;
        ev = EV_NONE;
        accept = 1'b0;
        case (phase)
            HUNT_SECOND:
            begin
                if (b == pre2_cfg)
                begin
                    wr_pos = 6'd2;
                    frame_sum = frame_sum + {8'h00, b};
                    frame_store[1] = b;
                    phase = COLLECT;
                end
                else
                begin
                    // the rejected byte is not looked at again as a first preamble
                    phase = HUNT_FIRST;
                    ev = EV_DROP;
                end
            end
            COLLECT:
            begin
                if (wr_pos >= 6'd62)
                begin
                    // no room left for payload plus checksum
                    phase = HUNT_FIRST;
                    ev = EV_DROP;
                end
                else
                begin
                    if (wr_pos == 6'd2)
                        len_byte = b;
                    if (wr_pos == 6'd3 && b != MSG_ID)
                    begin
                        phase = HUNT_FIRST;
                        ev = EV_DROP;
                    end
                    else
                    begin
                        frame_store[wr_pos] = b;
                        wr_pos = wr_pos + 6'd1;
                        frame_sum = frame_sum + {8'h00, b};
                        // signed test: short lengths jump straight to the checksum
                        if (int'(wr_pos) >= int'(len_byte) - 2)
                            phase = CHECK_LO;
                    end
                end
            end
            CHECK_LO:
            begin
                frame_store[wr_pos] = b;
                wr_pos = wr_pos + 6'd1;
                if (b == frame_sum[7:0])
                    phase = CHECK_HI;
                else
                begin
                    phase = HUNT_FIRST;
                    ev = EV_BADSUM;
                end
            end
            CHECK_HI:
            begin
                frame_store[wr_pos] = b;
                if (b == frame_sum[15:8])
                    accept = 1'b1;
                else
                    ev = EV_BADSUM;
                phase = HUNT_FIRST;
            end
            default:
            begin
                // every hunted byte restarts the frame at position zero
                wr_pos = 6'd0;
                frame_sum = {8'h00, b};
                frame_store[0] = b;
                phase = (b == pre1_cfg) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase

        if (accept && copy_cfg != 7'd0)
        begin
            n = (copy_cfg > 7'd64) ? 64 : int'(copy_cfg);
            for (i = 0; i < n; i++)
                expected_results.push_back({EV_BYTE, frame_store[i], 6'(i), i == n - 1});
        end
        else
            expected_results.push_back({ev, 8'h00, 6'd0, 1'b1});
    endtask

    function automatic void push_rx(input logic [7:0] b);
        rx_pending.push_back(b);
        queued++;
    endfunction

    // queue one frame for the current preambles, optionally spoilt
    task automatic queue_frame(input logic [7:0] len, input int fault);
        logic [15:0] sum;
        logic [7:0]  b;
        int          count;
        int          i;
        sum = {8'h00, pre1_cfg};
        push_rx(pre1_cfg);
        if (fault == FAULT_PRE2)
            push_rx(pre2_cfg ^ 8'($urandom_range(1, 255)));
        else
        begin
            push_rx(pre2_cfg);
            push_rx(len);
            sum = sum + {8'h00, pre2_cfg} + {8'h00, len};
            // body runs from the id byte up to the last payload byte; long
            // lengths are cut where the store overflows
            count = (len > 8'd5) ? int'(len) - 5 : 0;
            if (count > 60)
                count = 60;
            for (i = 0; i < count; i++)
            begin
                if (i != 0)
                    b = 8'($urandom);
                else if (fault == FAULT_ID)
                begin
                    b = 8'($urandom);
                    if (b == MSG_ID)
                        b = ~MSG_ID;
                end
                else
                    b = MSG_ID;
                push_rx(b);
                sum = sum + {8'h00, b};
            end
            if (len <= 8'd64)
            begin
                push_rx(sum[7:0] ^ ((fault == FAULT_SUMLO) ? 8'($urandom_range(1, 255)) : 8'h00));
                if (fault != FAULT_SUMLO)
                    push_rx(sum[15:8] ^
                            ((fault == FAULT_SUMHI) ? 8'($urandom_range(1, 255)) : 8'h00));
            end
        end
    endtask

    // mostly well-formed frames of small size, with noise and broken frames mixed in
    task automatic queue_traffic(input int budget);
        int target;
        int r;
        int k;
        int len;
        int fault;
        target = queued + budget;
        while (queued < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                // line noise, sometimes a lone first preamble
                if ($urandom_range(0, 2) == 0)
                    push_rx(pre1_cfg);
                k = $urandom_range(1, 4);
                repeat (k) push_rx(8'($urandom));
            end
            else if (r < 97)
            begin
                k = $urandom_range(0, 99);
                len = (k < 70) ? $urandom_range(0, 12) :
                      (k < 92) ? $urandom_range(13, 40) : $urandom_range(41, 64);
                k = $urandom_range(0, 9);
                fault = (k < 6)  ? FAULT_NONE :
                        (k == 6) ? FAULT_PRE2 :
                        (k == 7) ? FAULT_ID   :
                        (k == 8) ? FAULT_SUMLO : FAULT_SUMHI;
                // the id is only checked on frames of six bytes or more
                if (fault == FAULT_ID && len < 6)
                    len = len + 6;
                queue_frame(8'(len), fault);
            end
            else
                queue_frame(8'($urandom_range(65, 255)), FAULT_NONE);
        end
    endtask

    // wait until every byte is sent and every result seen, then let the block settle
    task automatic drain();
        while (rx_pending.size() != 0 || sending || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FIRST_PRE:  pre1_cfg = val;
            CFG_SECOND_PRE: pre2_cfg = val;
            default:        copy_cfg = val[6:0];
        endcase
    endtask

    task automatic set_config(input logic [7:0] p1, input logic [7:0] p2, input logic [7:0] cl);
        write_reg(CFG_FIRST_PRE, p1);
        write_reg(CFG_SECOND_PRE, p2);
        write_reg(CFG_COPY_LEN, cl);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus: directed frames on reset settings, then random traffic across settings
    initial
    begin
        pre1_cfg = FIRST_PRE_RST;
        pre2_cfg = SECOND_PRE_RST;
        copy_cfg = COPY_LEN_RST;
        phase = HUNT_FIRST;
        wr_pos = 6'd0;
        len_byte = 8'd0;
        frame_sum = 16'd0;
        foreach (frame_store[i])
            frame_store[i] = 8'h00;
        queued = 0;
        mismatches = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // byte extremes while hunting
        push_rx(8'h00);
        push_rx(8'hFF);
        // short frame: length under six skips the id check
        queue_frame(8'd3, FAULT_NONE);
        // wrong message id
        queue_frame(8'd9, FAULT_ID);
        // bad second preamble
        queue_frame(8'd7, FAULT_PRE2);
        // zero length with a bad high checksum byte
        queue_frame(8'd0, FAULT_SUMHI);
        // bad low checksum byte
        queue_frame(8'd8, FAULT_SUMLO);
        drain();

        for (ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_config(8'h00, 8'hFF, 8'h00);     // copy length zero
                1: set_config(8'hFF, 8'h00, 8'h7F);     // copy length saturates
                2: set_config(8'($urandom), 8'($urandom), 8'h01);
                3:
                begin
                    set_config(FIRST_PRE_RST, SECOND_PRE_RST, 8'd64);
                    // receiver holds off while frames keep arriving
                    hold_off_request = 1'b1;
                end
                4: set_config(8'($urandom), 8'($urandom), 8'hC5);
                default: set_config(8'($urandom), 8'($urandom),
                                    ($urandom_range(0, 3) == 0) ? 8'd64
                                                                : 8'($urandom_range(0, 24)));
            endcase
            // one frame long enough to overflow the store
            if (ph == 1)
                queue_frame(8'd200, FAULT_NONE);
            queue_traffic(28);
            drain();
        end

        if (mismatches == 0)
            $display("framed_message_parser_sum16 test passed");
        else
            $display("framed_message_parser_sum16 test failed");
        $finish;
    end

    // sender: bursts of beats with random gaps, valid held until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_beat_taken)
            begin
                sending = 1'b0;
                in_beat_taken = 1'b0;
            end
            if (!sending)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (rx_pending.size() > 0)
                begin
                    rx_byte <= rx_pending.pop_front();
                    sending = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
            end
            in_valid <= sending;
        end
    end

    // receiver: stretches of a random stall mode, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
                rdy = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 80);
                end
                else
                    seg_left--;
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) == 0);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ($urandom_range(0, 4) != 0);
                endcase
            end
            out_ready <= rdy;
        end
    end

    // monitor: predict on every byte beat, check every result beat in order
    always @(posedge clk)
    begin : result_monitor
        frame_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                parse_rx_byte(rx_byte);
                in_beat_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result ev=%0d byte=%02h idx=%0d last=%0b",
                                 $realtime, event_res, frame_byte, byte_index, last_of_run);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (event_res !== want.ev || frame_byte !== want.data ||
                        byte_index !== want.idx || last_of_run !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch: want ev=%0d byte=%02h idx=%0d last=%0b",
                                     $realtime, want.ev, want.data, want.idx, want.last);
                            $display("%0t: mismatch: got  ev=%0d byte=%02h idx=%0d last=%0b",
                                     $realtime, event_res, frame_byte, byte_index,
                                     last_of_run);
                        end
                    end
                end
            end
        end
    end

    // watchdog on beats, not on absolute time
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("framed_message_parser_sum16 test failed");
                $finish;
            end
        end
    end

endmodule
